### src/mia_pkg.sv
// Package for the MIPS64 integer ALU: operation codes, decode types and widths.
// Has no dependencies; the ALU top level imports it.
package mia_pkg;

   localparam int DATA_BITS  = 64;
   localparam int WORD_BITS  = 32;
   localparam int IMM_BITS   = 16;
   localparam int SA_BITS    = 5;
   localparam int SHAMT_BITS = 6;
   localparam int CODE_BITS  = 6;

   typedef enum logic [CODE_BITS-1:0] {
      OP_ADD    = 6'd0,
      OP_ADDU   = 6'd1,
      OP_SUB    = 6'd2,
      OP_SUBU   = 6'd3,
      OP_AND    = 6'd4,
      OP_OR     = 6'd5,
      OP_XOR    = 6'd6,
      OP_NOR    = 6'd7,
      OP_SLT    = 6'd8,
      OP_SLTU   = 6'd9,
      OP_DADDU  = 6'd10,
      OP_DSUBU  = 6'd11,
      OP_SLL    = 6'd12,
      OP_SRL    = 6'd13,
      OP_SRA    = 6'd14,
      OP_DSLL   = 6'd15,
      OP_DSRL   = 6'd16,
      OP_DSRA   = 6'd17,
      OP_DSLL32 = 6'd18,
      OP_DSRL32 = 6'd19,
      OP_DSRA32 = 6'd20,
      OP_SLLV   = 6'd21,
      OP_SRLV   = 6'd22,
      OP_SRAV   = 6'd23,
      OP_ADDIU  = 6'd24,
      OP_DADDIU = 6'd25,
      OP_ANDI   = 6'd26,
      OP_ORI    = 6'd27,
      OP_XORI   = 6'd28,
      OP_LUI    = 6'd29,
      OP_SLTI   = 6'd30,
      OP_SLTIU  = 6'd31
   } op_type;

   typedef enum logic [2:0] {
      UNIT_ADD,
      UNIT_LOGIC,
      UNIT_SLT,
      UNIT_SHIFT,
      UNIT_ZERO
   } unit_type;

   typedef enum logic [1:0] {
      LOGIC_AND,
      LOGIC_OR,
      LOGIC_XOR,
      LOGIC_NOR
   } logic_type;

   typedef struct packed {
      unit_type               unit;
      logic_type              logic_op;
      logic                   sub;
      logic                   word;
      logic                   lt_signed;
      logic                   shift_right;
      logic                   shift_arith;
      logic [SHAMT_BITS-1:0]  shamt;
   } ctrl_type;

endpackage

### src/mips64_integer_alu_top.sv
// MIPS64 integer ALU: three-stage pipeline of decode, execute and sign extension.
// Depends on mia_pkg for operation codes, decode types and widths.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_operand_a, req_operand_b,
//                                            req_shift_amount, req_immediate
//   rsp      out        rsp_valid/rsp_stall  rsp_result
//
// An accepted word is registered in stage one, then stage two, then stage three, where it
// raises rsp_valid; one word can enter each cycle while req_stall is low.
// Stage one decodes and picks operands, stage two runs the adder or the barrel shifter,
// stage three sign-extends 32-bit results into the output register.
// Reset empties all three stages; the block has no other state.
// A stall on rsp holds the output stage, and an earlier full stage waits only while every
// stage after it is full; req_stall rises only when all three are full and rsp is stalled.
module mips64_integer_alu_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mia_pkg::CODE_BITS-1:0]    req_type,
   input  logic [mia_pkg::DATA_BITS-1:0]    req_operand_a,
   input  logic [mia_pkg::DATA_BITS-1:0]    req_operand_b,
   input  logic [mia_pkg::SA_BITS-1:0]      req_shift_amount,
   input  logic [mia_pkg::IMM_BITS-1:0]     req_immediate,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mia_pkg::DATA_BITS-1:0]    rsp_result
);
   import mia_pkg::*;

   logic                  ready1, ready2, ready3;

   logic                  v1_ff, v2_ff, v3_ff;
   ctrl_type              ctrl1_ff, ctrl1_in;
   logic [DATA_BITS-1:0]  a1_ff, a1_in, b1_ff, b1_in;
   logic                  word2_ff;
   logic [DATA_BITS-1:0]  res2_ff, res2_in;
   logic [DATA_BITS-1:0]  res3_ff, res3_in;

   logic [DATA_BITS-1:0]  simm, zimm;
   logic [DATA_BITS:0]    sum;
   logic                  lt_u, lt_s;
   logic [DATA_BITS-1:0]  logic_res, shift_res;

   // A stage may load when it is empty or when its contents move on this cycle.
   assign ready3    = !v3_ff || !rsp_stall;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;
   assign rsp_valid = v3_ff;
   assign rsp_result = res3_ff;

   // Stage one: decode and operand selection.
   always_comb begin
      simm = {{(DATA_BITS-IMM_BITS){req_immediate[IMM_BITS-1]}}, req_immediate};
      zimm = {{(DATA_BITS-IMM_BITS){1'b0}}, req_immediate};
      ctrl1_in.unit        = UNIT_ZERO;
      ctrl1_in.logic_op    = LOGIC_AND;
      ctrl1_in.sub         = 1'b0;
      ctrl1_in.word        = 1'b0;
      ctrl1_in.lt_signed   = 1'b0;
      ctrl1_in.shift_right = 1'b0;
      ctrl1_in.shift_arith = 1'b0;
      ctrl1_in.shamt       = {1'b0, req_shift_amount};
      a1_in = req_operand_a;
      b1_in = req_operand_b;
      case (op_type'(req_type))
         OP_ADD, OP_ADDU: begin
            ctrl1_in.unit = UNIT_ADD;
            ctrl1_in.word = 1'b1;
         end
         OP_SUB, OP_SUBU: begin
            ctrl1_in.unit = UNIT_ADD;
            ctrl1_in.sub  = 1'b1;
            ctrl1_in.word = 1'b1;
         end
         OP_AND: ctrl1_in.unit = UNIT_LOGIC;
         OP_OR: begin
            ctrl1_in.unit     = UNIT_LOGIC;
            ctrl1_in.logic_op = LOGIC_OR;
         end
         OP_XOR: begin
            ctrl1_in.unit     = UNIT_LOGIC;
            ctrl1_in.logic_op = LOGIC_XOR;
         end
         OP_NOR: begin
            ctrl1_in.unit     = UNIT_LOGIC;
            ctrl1_in.logic_op = LOGIC_NOR;
         end
         OP_SLT: begin
            ctrl1_in.unit      = UNIT_SLT;
            ctrl1_in.sub       = 1'b1;
            ctrl1_in.lt_signed = 1'b1;
         end
         OP_SLTU: begin
            ctrl1_in.unit = UNIT_SLT;
            ctrl1_in.sub  = 1'b1;
         end
         OP_DADDU: ctrl1_in.unit = UNIT_ADD;
         OP_DSUBU: begin
            ctrl1_in.unit = UNIT_ADD;
            ctrl1_in.sub  = 1'b1;
         end
         OP_SLL, OP_SLLV: begin
            ctrl1_in.unit = UNIT_SHIFT;
            ctrl1_in.word = 1'b1;
         end
         OP_SRL, OP_SRLV: begin
            ctrl1_in.unit        = UNIT_SHIFT;
            ctrl1_in.word        = 1'b1;
            ctrl1_in.shift_right = 1'b1;
            b1_in = {{(DATA_BITS-WORD_BITS){1'b0}}, req_operand_b[WORD_BITS-1:0]};
         end
         OP_SRA, OP_SRAV: begin
            ctrl1_in.unit        = UNIT_SHIFT;
            ctrl1_in.word        = 1'b1;
            ctrl1_in.shift_right = 1'b1;
            ctrl1_in.shift_arith = 1'b1;
            b1_in = {{(DATA_BITS-WORD_BITS){req_operand_b[WORD_BITS-1]}},
                     req_operand_b[WORD_BITS-1:0]};
         end
         OP_DSLL: ctrl1_in.unit = UNIT_SHIFT;
         OP_DSRL: begin
            ctrl1_in.unit        = UNIT_SHIFT;
            ctrl1_in.shift_right = 1'b1;
         end
         OP_DSRA: begin
            ctrl1_in.unit        = UNIT_SHIFT;
            ctrl1_in.shift_right = 1'b1;
            ctrl1_in.shift_arith = 1'b1;
         end
         OP_DSLL32: begin
            ctrl1_in.unit  = UNIT_SHIFT;
            ctrl1_in.shamt = {1'b1, req_shift_amount};
         end
         OP_DSRL32: begin
            ctrl1_in.unit        = UNIT_SHIFT;
            ctrl1_in.shift_right = 1'b1;
            ctrl1_in.shamt       = {1'b1, req_shift_amount};
         end
         OP_DSRA32: begin
            ctrl1_in.unit        = UNIT_SHIFT;
            ctrl1_in.shift_right = 1'b1;
            ctrl1_in.shift_arith = 1'b1;
            ctrl1_in.shamt       = {1'b1, req_shift_amount};
         end
         OP_ADDIU: begin
            ctrl1_in.unit = UNIT_ADD;
            ctrl1_in.word = 1'b1;
            b1_in = simm;
         end
         OP_DADDIU: begin
            ctrl1_in.unit = UNIT_ADD;
            b1_in = simm;
         end
         OP_ANDI: begin
            ctrl1_in.unit = UNIT_LOGIC;
            b1_in = zimm;
         end
         OP_ORI: begin
            ctrl1_in.unit     = UNIT_LOGIC;
            ctrl1_in.logic_op = LOGIC_OR;
            b1_in = zimm;
         end
         OP_XORI: begin
            ctrl1_in.unit     = UNIT_LOGIC;
            ctrl1_in.logic_op = LOGIC_XOR;
            b1_in = zimm;
         end
         OP_LUI: begin
            // Computed as zero plus the shifted immediate, then sign-extended as a word.
            ctrl1_in.unit = UNIT_ADD;
            ctrl1_in.word = 1'b1;
            a1_in = '0;
            b1_in = {{(DATA_BITS-WORD_BITS){1'b0}}, req_immediate, {IMM_BITS{1'b0}}};
         end
         OP_SLTI: begin
            ctrl1_in.unit      = UNIT_SLT;
            ctrl1_in.sub       = 1'b1;
            ctrl1_in.lt_signed = 1'b1;
            b1_in = simm;
         end
         OP_SLTIU: begin
            ctrl1_in.unit = UNIT_SLT;
            ctrl1_in.sub  = 1'b1;
            b1_in = simm;
         end
         default: ctrl1_in.unit = UNIT_ZERO;
      endcase
      // The variable shifts take their amount from the low five bits of rs.
      if (op_type'(req_type) == OP_SLLV || op_type'(req_type) == OP_SRLV ||
          op_type'(req_type) == OP_SRAV) begin
         ctrl1_in.shamt = {1'b0, req_operand_a[SA_BITS-1:0]};
      end
   end

   // Stage two: one adder serves add, subtract and both compares.
   always_comb begin
      sum = {1'b0, a1_ff} + {1'b0, (ctrl1_ff.sub ? ~b1_ff : b1_ff)}
            + {{DATA_BITS{1'b0}}, ctrl1_ff.sub};
      lt_u = !sum[DATA_BITS];
      lt_s = (a1_ff[DATA_BITS-1] != b1_ff[DATA_BITS-1]) ? a1_ff[DATA_BITS-1]
                                                         : sum[DATA_BITS-1];
      case (ctrl1_ff.logic_op)
         LOGIC_AND: logic_res = a1_ff & b1_ff;
         LOGIC_OR:  logic_res = a1_ff | b1_ff;
         LOGIC_XOR: logic_res = a1_ff ^ b1_ff;
         LOGIC_NOR: logic_res = ~(a1_ff | b1_ff);
         default:   logic_res = '0;
      endcase
      if (!ctrl1_ff.shift_right) begin
         shift_res = b1_ff << ctrl1_ff.shamt;
      end else if (ctrl1_ff.shift_arith) begin
         shift_res = DATA_BITS'($signed(b1_ff) >>> ctrl1_ff.shamt);
      end else begin
         shift_res = b1_ff >> ctrl1_ff.shamt;
      end
      case (ctrl1_ff.unit)
         UNIT_ADD:   res2_in = sum[DATA_BITS-1:0];
         UNIT_LOGIC: res2_in = logic_res;
         UNIT_SLT:   res2_in = {{(DATA_BITS-1){1'b0}}, (ctrl1_ff.lt_signed ? lt_s : lt_u)};
         UNIT_SHIFT: res2_in = shift_res;
         default:    res2_in = '0;
      endcase
   end

   // Stage three: 32-bit operations sign-extend bit 31.
   assign res3_in = word2_ff ? {{(DATA_BITS-WORD_BITS){res2_ff[WORD_BITS-1]}},
                                res2_ff[WORD_BITS-1:0]}
                             : res2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         ctrl1_ff <= ctrl1_in;
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
      end
      if (ready2) begin
         word2_ff <= ctrl1_ff.word;
         res2_ff  <= res2_in;
      end
      if (ready3) begin
         res3_ff <= res3_in;
      end
   end

`ifndef SYNTH
   logic [1:0] occupancy;
   logic       in_take, out_take;

   assign occupancy = 2'($countones({v1_ff, v2_ff, v3_ff}));
   assign in_take   = req_valid && !req_stall;
   assign out_take  = rsp_valid && !rsp_stall;

   // The input side stalls only when every stage holds a word.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff))
      else $error("input stalled while the pipeline has room");

   // A word leaving stage one must arrive in stage two.
   assert property (@(posedge clock) disable iff (reset)
      (v1_ff && ready2) |=> v2_ff)
      else $error("word lost between stage one and stage two");

   // Words in flight change only by what enters and what leaves.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ({1'b0, occupancy} ==
                {1'b0, $past(occupancy)} + {2'b00, $past(in_take)} - {2'b00, $past(out_take)}))
      else $error("pipeline word count does not match the handshakes");
`endif

endmodule
